FILE: rtl/m4mf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4mf_pkg
// Shared types and constants for the fixed-point 4x4 matrix multiplier.
// ----------------------------------------------------------------------------
package m4mf_pkg;

  localparam int MATRIX_SIZE = 4;
  localparam int ELEM_COUNT  = MATRIX_SIZE * MATRIX_SIZE;
  localparam int IDX_W       = 4;
  localparam int SZ_W        = $clog2(MATRIX_SIZE);
  localparam int DATA_W      = 32;
  localparam int FRAC_BITS   = 16;
  localparam int PROD_W      = 2 * DATA_W;
  // room for MATRIX_SIZE full products plus a guard bit
  localparam int ACC_W       = PROD_W + SZ_W + 1;

  typedef struct packed {
    logic [IDX_W-1:0]         element_index;
    logic signed [DATA_W-1:0] left_element;
    logic signed [DATA_W-1:0] right_element;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] product_element;
    logic [IDX_W-1:0]         product_index;
    logic                     clipped;
    logic                     final_element;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

endpackage

FILE: rtl/matrix4_multiply_fixed.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4_multiply_fixed
// Signed Q16.16 4x4 matrix product from two element stores and one MAC.
// ----------------------------------------------------------------------------
//  channel | ports                     | handshake
//  --------+---------------------------+---------------------------------
//  input   | in_item                   | accepted when start && !busy
//  result  | out_valid, out_item       | one-cycle strobe, no back-pressure
//
//  the load beat at index 15 starts the product
//  the product runs one multiply-accumulate per cycle through a single MAC
//  results come in row-major order, the last one with busy already low
//  rst_n (synchronous) clears control only; store contents stay undefined
//  until written
// ----------------------------------------------------------------------------
module matrix4_multiply_fixed (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  m4mf_pkg::in_item_t  in_item,
  output logic                out_valid,
  output m4mf_pkg::out_item_t out_item
);
  import m4mf_pkg::*;

  localparam int CNT_W = 3 * SZ_W;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic accept, ld_we, issue, last_issue;
  logic [SZ_W-1:0] row_i, col_k, sum_j;
  logic [IDX_W-1:0] left_ra, right_ra;
  logic [DATA_W-1:0] left_rd, right_rd;

  // stage 1: ram data arrives
  logic s1_vld_r, s1_first_r, s1_last_r;
  logic [IDX_W-1:0] s1_pos_r;
  // stage 2: product
  logic s2_vld_r, s2_first_r, s2_last_r;
  logic [IDX_W-1:0] s2_pos_r;
  logic signed [PROD_W-1:0] prod_r;
  // stage 3: accumulator
  logic s3_done_r;
  logic [IDX_W-1:0] s3_pos_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt, prod_ext;
  // output
  logic signed [ACC_W-1:0] shifted;
  logic fits;
  logic out_valid_r;
  out_item_t out_item_r, out_item_nxt;

  assign accept = start && !busy;
  assign {row_i, col_k, sum_j} = cnt_r;
  assign last_issue = (cnt_r == CNT_W'(ELEM_COUNT * MATRIX_SIZE - 1));
  assign left_ra  = IDX_W'({row_i, sum_j});
  assign right_ra = IDX_W'({sum_j, col_k});

  m4mf_ram #(.WIDTH(DATA_W), .DEPTH(ELEM_COUNT)) u_left_ram (
    .clk  (clk),
    .we   (ld_we),
    .waddr(in_item.element_index),
    .wdata(in_item.left_element),
    .raddr(left_ra),
    .rdata(left_rd)
  );

  m4mf_ram #(.WIDTH(DATA_W), .DEPTH(ELEM_COUNT)) u_right_ram (
    .clk  (clk),
    .we   (ld_we),
    .waddr(in_item.element_index),
    .wdata(in_item.right_element),
    .raddr(right_ra),
    .rdata(right_rd)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_item.element_index == IDX_W'(ELEM_COUNT - 1)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (s3_done_r && s3_pos_r == IDX_W'(ELEM_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy  = 1'b1;
    issue = 1'b0;
    ld_we = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy  = 1'b0;
        ld_we = start && (32'(in_item.element_index) < ELEM_COUNT);
      end
      ST_RUN:   issue = 1'b1;
      ST_DRAIN: busy  = 1'b1;
      default:  busy  = 1'b1;
    endcase
  end

  assign cnt_nxt = issue ? cnt_r + CNT_W'(1) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_done_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      s1_vld_r    <= issue;
      s2_vld_r    <= s1_vld_r;
      s3_done_r   <= s2_vld_r && s2_last_r;
      out_valid_r <= s3_done_r;
    end
  end

  assign prod_ext = {{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign acc_nxt  = s2_first_r ? prod_ext : acc_r + prod_ext;

  always_ff @(posedge clk) begin
    s1_first_r <= (sum_j == '0);
    s1_last_r  <= (sum_j == SZ_W'(MATRIX_SIZE - 1));
    s1_pos_r   <= IDX_W'({row_i, col_k});
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_pos_r   <= s1_pos_r;
    prod_r     <= $signed(left_rd) * $signed(right_rd);
    if (s2_vld_r) begin
      acc_r <= acc_nxt;
    end
    s3_pos_r   <= s2_pos_r;
    out_item_r <= out_item_nxt;
  end

  // arithmetic shift, then saturate to 32 bits
  assign shifted = acc_r >>> FRAC_BITS;
  assign fits = (&shifted[ACC_W-1:DATA_W-1]) || !(|shifted[ACC_W-1:DATA_W-1]);

  always_comb begin
    out_item_nxt.product_index = s3_pos_r;
    out_item_nxt.final_element = (s3_pos_r == IDX_W'(ELEM_COUNT - 1));
    out_item_nxt.clipped       = !fits;
    if (fits) begin
      out_item_nxt.product_element = shifted[DATA_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      out_item_nxt.product_element = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      out_item_nxt.product_element = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: rtl/m4mf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4mf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module m4mf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/m4mf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4mf_checker
// Port-level checks on the matrix multiplier's result sequencing.
// ----------------------------------------------------------------------------
module m4mf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input m4mf_pkg::in_item_t  in_item,
  input logic                out_valid,
  input m4mf_pkg::out_item_t out_item
);
  import m4mf_pkg::*;

  // last load beat always starts a product
  a_trigger_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.element_index == IDX_W'(ELEM_COUNT - 1) |=> busy)
    else $error("product not started after last load beat");

  // result beats follow one another in row-major order
  a_burst_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.final_element |-> ##MATRIX_SIZE
      (out_valid &&
       out_item.product_index == $past(out_item.product_index, MATRIX_SIZE) + 1'b1))
    else $error("result burst broken or out of order");

  // only the final beat may show while the block is free
  a_busy_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.final_element |-> busy)
    else $error("result beat while idle");

  a_final_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.final_element |-> !busy)
    else $error("still busy on final beat");

  a_final_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.final_element ==
      (out_item.product_index == IDX_W'(ELEM_COUNT - 1)))
    else $error("final mark on wrong beat");

endmodule

bind matrix4_multiply_fixed m4mf_checker u_m4mf_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_item  (in_item),
  .out_valid(out_valid),
  .out_item (out_item)
);
